// ----- hdl/ftbl_pkg.sv -----
// Shared types, constants and helpers of the token bucket limiter.
// Used by every module of the block; depends on nothing.
package ftbl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int NCNT_W = $clog2(MAX_RESULTS + 1);
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_IDX_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam int BAL_W = 33;
	localparam int TOTAL_W = 48;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
	localparam logic [31:0] REFILL_RESET = 32'd1048576;

	localparam logic REG_REFILL = 1'b0;

	localparam logic [1:0] OP_REQUEST = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_STATS = 2'd2;
	localparam logic [1:0] OP_STOP = 2'd3;

	localparam logic [2:0] ST_NOW = 3'd0;
	localparam logic [2:0] ST_QUEUED = 3'd1;
	localparam logic [2:0] ST_REJECT = 3'd2;
	localparam logic [2:0] ST_FROMQ = 3'd3;
	localparam logic [2:0] ST_RELEASED = 3'd4;
	localparam logic [2:0] ST_PASS = 3'd5;
	localparam logic [2:0] ST_STATS = 3'd6;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  tag;
		logic [31:0] bytes;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  tag;
		logic [31:0] rem;
	} waiter_t;

	typedef struct packed {
		logic [7:0]         tag;
		logic [2:0]         status;
		logic [TOTAL_W-1:0] alloc;
	} result_t;

	function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
			input logic [BAL_W-1:0] v);
		logic [TOTAL_W:0] sum;
		sum = {1'b0, total} + (TOTAL_W+1)'(v);
		return (sum >= {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
	endfunction

endpackage

// ----- hdl/fifo_token_bucket_limiter_unit.sv -----
// Top level of the byte-credit limiter: configuration register, input stage,
// command queue and executor. Depends on ftbl_pkg, ftbl_front, ftbl_cmd_fifo, ftbl_back.
//
// Channel   Direction  Handshake                Content
// s_axis    in         tvalid/tready            tuser operation, tdata tag and bytes
// m_axis    out        tvalid/tready            tuser status, tdata tag and total, tlast
// apb       in         psel/penable/pready      refill_amount at byte address 0
//
// A request or stats beat passes through the input register and then waits at the head
// of the command queue, where the executor decides it and loads the output register;
// back to back they sustain one beat per cycle while the output is not stalled.
// A refill tick or stop is decoded in S_IDLE, passes S_RD and S_EV for each waiter it
// examines, due to the registered waiter memory read, and sends its last result in S_FIN.
// Reset is asynchronous and active low; the waiter memory needs no clearing pass.
// A stalled output holds its beat while the command queue keeps accepting input until full.
module fifo_token_bucket_limiter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // request_tag[7:0], request_bytes[39:8]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // result_tag[7:0], allocated_bytes[55:8]
	output logic [2:0]  m_axis_tuser,  // status[2:0]
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] refill_q;
	logic push;
	logic push_ready;
	ftbl_pkg::cmd_t push_cmd;
	logic cmd_valid;
	logic cmd_pop;
	ftbl_pkg::cmd_t cmd;
	ftbl_pkg::result_t res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == ftbl_pkg::REG_REFILL) ? refill_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refill_q <= ftbl_pkg::REFILL_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == ftbl_pkg::REG_REFILL) begin
			refill_q <= pwdata;
		end
	end

	ftbl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_op      (s_axis_tuser),
		.in_tag     (s_axis_tdata[7:0]),
		.in_bytes   (s_axis_tdata[39:8]),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	ftbl_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	ftbl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.refill    (refill_q),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {res.alloc, res.tag};
	assign m_axis_tuser = res.status;

endmodule

// ----- hdl/ftbl_front.sv -----
// Input stage: takes one beat per cycle into a register while the command queue has room,
// and hands it on as a command. Depends on ftbl_pkg.
module ftbl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  logic [7:0]        in_tag,
	input  logic [31:0]       in_bytes,
	output logic              push,
	input  logic              push_ready,
	output ftbl_pkg::cmd_t    push_cmd
);

	logic v_s1;
	ftbl_pkg::cmd_t cmd_s1;

	assign push = v_s1;
	assign push_cmd = cmd_s1;
	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.op <= in_op;
			cmd_s1.tag <= in_tag;
			cmd_s1.bytes <= in_bytes;
		end
	end

endmodule

// ----- hdl/ftbl_cmd_fifo.sv -----
// Short command queue between the input stage and the executor.
// Depends on ftbl_pkg.
module ftbl_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  ftbl_pkg::cmd_t    push_cmd,
	output logic              pop_valid,
	input  logic              pop,
	output ftbl_pkg::cmd_t    pop_cmd
);

	ftbl_pkg::cmd_t entry_q [ftbl_pkg::CMDQ_DEPTH];
	logic [ftbl_pkg::CMDQ_IDX_W-1:0] wr_ptr_q;
	logic [ftbl_pkg::CMDQ_IDX_W-1:0] rd_ptr_q;
	logic [ftbl_pkg::CMDQ_CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign push_ready = cnt_q != ftbl_pkg::CMDQ_CNT_W'(ftbl_pkg::CMDQ_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == ftbl_pkg::CMDQ_IDX_W'(ftbl_pkg::CMDQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == ftbl_pkg::CMDQ_IDX_W'(ftbl_pkg::CMDQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hdl/ftbl_back.sv -----
// Executor: credit balance, waiter queue memory, stats total and the output register.
// Depends on ftbl_pkg.
module ftbl_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [31:0]                  refill,
	input  logic                         cmd_valid,
	output logic                         cmd_pop,
	input  ftbl_pkg::cmd_t               cmd,
	output logic                         out_valid,
	input  logic                         out_ready,
	output ftbl_pkg::result_t            out_res,
	output logic                         out_last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD = 2'd1;
	localparam logic [1:0] S_EV = 2'd2;
	localparam logic [1:0] S_FIN = 2'd3;

	logic [1:0] state_q, state_d;
	logic stop_mode_q, stop_mode_d;
	logic [ftbl_pkg::NCNT_W-1:0] n_q, n_d;
	logic [ftbl_pkg::BAL_W-1:0] balance_q, balance_d;
	logic [ftbl_pkg::TOTAL_W-1:0] total_q, total_d;
	logic stopped_q, stopped_d;
	logic [ftbl_pkg::QIDX_W-1:0] head_q, head_d;
	logic [ftbl_pkg::QCNT_W-1:0] count_q, count_d;
	logic pend_v_q, pend_v_d;
	ftbl_pkg::result_t pend_q, pend_d;
	logic ov_q;
	ftbl_pkg::result_t o_q;
	logic o_last_q;

	ftbl_pkg::waiter_t mem [ftbl_pkg::QUEUE_DEPTH];
	ftbl_pkg::waiter_t rd_q;
	logic mem_we;
	logic [ftbl_pkg::QIDX_W-1:0] mem_wa;
	ftbl_pkg::waiter_t mem_wd;

	logic ld;
	ftbl_pkg::result_t ld_res;
	logic ld_last;
	logic out_free;
	logic [ftbl_pkg::QIDX_W:0] tail_sum;
	logic [ftbl_pkg::QIDX_W-1:0] tail;
	logic [ftbl_pkg::QIDX_W-1:0] head_next;

	assign out_valid = ov_q;
	assign out_res = o_q;
	assign out_last = o_last_q;
	assign out_free = !ov_q || out_ready;

	assign tail_sum = (ftbl_pkg::QIDX_W+1)'(head_q) + (ftbl_pkg::QIDX_W+1)'(count_q);
	assign tail = (tail_sum >= (ftbl_pkg::QIDX_W+1)'(ftbl_pkg::QUEUE_DEPTH)) ?
		ftbl_pkg::QIDX_W'(tail_sum - (ftbl_pkg::QIDX_W+1)'(ftbl_pkg::QUEUE_DEPTH)) :
		tail_sum[ftbl_pkg::QIDX_W-1:0];
	assign head_next = (head_q == ftbl_pkg::QIDX_W'(ftbl_pkg::QUEUE_DEPTH - 1)) ?
		'0 : head_q + 1'b1;

	always_comb begin
		state_d = state_q;
		stop_mode_d = stop_mode_q;
		n_d = n_q;
		balance_d = balance_q;
		total_d = total_q;
		stopped_d = stopped_q;
		head_d = head_q;
		count_d = count_q;
		pend_v_d = pend_v_q;
		pend_d = pend_q;
		cmd_pop = 1'b0;
		ld = 1'b0;
		ld_res = '0;
		ld_last = 1'b0;
		mem_we = 1'b0;
		mem_wa = head_q;
		mem_wd = rd_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					case (cmd.op)
						ftbl_pkg::OP_REQUEST: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								ld = 1'b1;
								ld_last = 1'b1;
								ld_res.tag = cmd.tag;
								if (stopped_q || refill == '0) begin
									ld_res.status = ftbl_pkg::ST_PASS;
								end else if (balance_q >= {1'b0, cmd.bytes}) begin
									ld_res.status = ftbl_pkg::ST_NOW;
									balance_d = balance_q - {1'b0, cmd.bytes};
									total_d = ftbl_pkg::sat_add(total_q, {1'b0, cmd.bytes});
								end else if (count_q ==
										ftbl_pkg::QCNT_W'(ftbl_pkg::QUEUE_DEPTH)) begin
									ld_res.status = ftbl_pkg::ST_REJECT;
								end else begin
									ld_res.status = ftbl_pkg::ST_QUEUED;
									mem_we = 1'b1;
									mem_wa = tail;
									mem_wd.tag = cmd.tag;
									mem_wd.rem = cmd.bytes;
									count_d = count_q + 1'b1;
								end
							end
						end
						ftbl_pkg::OP_STATS: begin
							if (out_free) begin
								cmd_pop = 1'b1;
								ld = 1'b1;
								ld_last = 1'b1;
								ld_res.status = ftbl_pkg::ST_STATS;
								ld_res.alloc = total_q;
								total_d = '0;
							end
						end
						ftbl_pkg::OP_TICK: begin
							cmd_pop = 1'b1;
							if (!stopped_q && count_q != '0) begin
								if (balance_q < {1'b0, refill}) begin
									balance_d = balance_q + {1'b0, refill};
								end
								stop_mode_d = 1'b0;
								n_d = '0;
								state_d = S_RD;
							end
						end
						ftbl_pkg::OP_STOP: begin
							cmd_pop = 1'b1;
							stopped_d = 1'b1;
							if (count_q != '0) begin
								stop_mode_d = 1'b1;
								n_d = '0;
								state_d = S_RD;
							end
						end
						default: begin
							cmd_pop = 1'b1;
						end
					endcase
				end
			end
			S_RD: begin
				state_d = S_EV;
			end
			S_EV: begin
				if (!stop_mode_q && balance_q < {1'b0, rd_q.rem}) begin
					mem_we = 1'b1;
					mem_wa = head_q;
					mem_wd.tag = rd_q.tag;
					mem_wd.rem = rd_q.rem - balance_q[31:0];
					total_d = ftbl_pkg::sat_add(total_q, balance_q);
					balance_d = '0;
					state_d = S_FIN;
				end else if (!pend_v_q || out_free) begin
					if (pend_v_q) begin
						ld = 1'b1;
						ld_res = pend_q;
					end
					pend_v_d = 1'b1;
					pend_d.tag = rd_q.tag;
					pend_d.status = stop_mode_q ? ftbl_pkg::ST_RELEASED : ftbl_pkg::ST_FROMQ;
					pend_d.alloc = '0;
					if (!stop_mode_q) begin
						balance_d = balance_q - {1'b0, rd_q.rem};
						total_d = ftbl_pkg::sat_add(total_q, {1'b0, rd_q.rem});
					end
					head_d = head_next;
					count_d = count_q - 1'b1;
					n_d = n_q + 1'b1;
					if (count_q == ftbl_pkg::QCNT_W'(1) ||
							n_q == ftbl_pkg::NCNT_W'(ftbl_pkg::MAX_RESULTS - 1)) begin
						state_d = S_FIN;
					end else begin
						state_d = S_RD;
					end
				end
			end
			S_FIN: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					ld = 1'b1;
					ld_res = pend_q;
					ld_last = 1'b1;
					pend_v_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stop_mode_q <= 1'b0;
			n_q <= '0;
			balance_q <= ftbl_pkg::BAL_W'(ftbl_pkg::REFILL_RESET);
			total_q <= '0;
			stopped_q <= 1'b0;
			head_q <= '0;
			count_q <= '0;
			pend_v_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stop_mode_q <= stop_mode_d;
			n_q <= n_d;
			balance_q <= balance_d;
			total_q <= total_d;
			stopped_q <= stopped_d;
			head_q <= head_d;
			count_q <= count_d;
			pend_v_q <= pend_v_d;
			if (ld) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_q <= pend_d;
		if (ld) begin
			o_q <= ld_res;
			o_last_q <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[head_q];
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ftbl_pkg::QCNT_W'(ftbl_pkg::QUEUE_DEPTH))
		else $error("waiter count beyond queue depth");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q)
		else $error("pending result left over in idle");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (count_q != '0))
		else $error("head read with empty waiter queue");

	a_partial_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV && !stop_mode_q && balance_q < {1'b0, rd_q.rem})
		|=> (balance_q == '0 && state_q == S_FIN))
		else $error("partial charge did not drain the balance");

endmodule
